// File: rtl/core/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request line parser package
// Shared types, character constants and method/marker tables.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  localparam int unsigned METHOD_CNT = 9;
  localparam int unsigned METHOD_MAX = 7;
  localparam int unsigned MARKER_LEN = 5;

  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_H  = 8'h48;

  // Method names in code order, padded with zeros past their length.
  localparam logic [7:0] METHOD_TEXT [METHOD_CNT][METHOD_MAX] = '{
    '{"O", "P", "T", "I", "O", "N", "S"},
    '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00},
    '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00},
    '{"P", "A", "T", "C", "H", 8'h00, 8'h00},
    '{"D", "E", "L", "E", "T", "E", 8'h00},
    '{"T", "R", "A", "C", "E", 8'h00, 8'h00},
    '{"C", "O", "N", "N", "E", "C", "T"}
  };

  localparam logic [3:0] METHOD_LEN [METHOD_CNT] = '{
    4'd7, 4'd3, 4'd4, 4'd3, 4'd4, 4'd5, 4'd6, 4'd5, 4'd7
  };

  localparam logic [7:0] MARKER_TEXT [MARKER_LEN] = '{"H", "T", "T", "P", "/"};

  typedef enum logic [5:0] {
    PH_METHOD  = 6'b000001,
    PH_URI     = 6'b000010,
    PH_SCAN    = 6'b000100,
    PH_VERSION = 6'b001000,
    PH_TAIL    = 6'b010000,
    PH_ERROR   = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    TAG_NONE    = 2'd0,
    TAG_METHOD  = 2'd1,
    TAG_URI     = 2'd2,
    TAG_VERSION = 2'd3
  } tag_e;

  typedef enum logic [1:0] {
    ST_PARSING = 2'd0,
    ST_OK      = 2'd1,
    ST_ERROR   = 2'd2
  } status_e;

  // Parse context carried from one word to the next.
  typedef struct packed {
    phase_e               phase;
    logic [METHOD_CNT-1:0] cand;    // methods still matching the prefix seen
    logic [3:0]           mlen;     // method bytes seen, saturates at 8
    logic [2:0]           mcnt;     // marker bytes matched
    logic                 nl;       // newline seen while scanning
    logic [3:0]           mfound;   // accepted method code
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:  PH_METHOD,
    cand:   '1,
    mlen:   4'd0,
    mcnt:   3'd0,
    nl:     1'b0,
    mfound: 4'd0
  };

  typedef struct packed {
    logic [7:0] data;
    tag_e       tag;
    logic       done;
    status_e    status;
    logic [3:0] mcode;
  } result_t;

endpackage

// File: rtl/core/hrlp_step.sv
// ----------------------------------------------------------------------------
// HTTP request line parser step
// Combinational update of the parse context for one message byte.
// ----------------------------------------------------------------------------
module hrlp_step (
  input  hrlp_pkg::parse_state_t st_i,
  input  logic [7:0]             byte_i,
  input  logic                   start_i,
  input  logic                   end_i,
  output hrlp_pkg::parse_state_t st_o,
  output hrlp_pkg::result_t      res_o
);

  hrlp_pkg::parse_state_t cur;
  hrlp_pkg::parse_state_t nxt;
  hrlp_pkg::tag_e         tag;
  logic [hrlp_pkg::METHOD_CNT-1:0] hit;
  logic                   found;
  logic [3:0]             code;
  logic [2:0]             cnt;

  always_comb begin
    cur   = start_i ? hrlp_pkg::PARSE_RESET : st_i;
    nxt   = cur;
    tag   = hrlp_pkg::TAG_NONE;
    found = 1'b0;
    code  = 4'd0;
    cnt   = 3'd0;
    for (int i = 0; i < hrlp_pkg::METHOD_CNT; i++) begin
      hit[i] = cur.cand[i] && (cur.mlen == hrlp_pkg::METHOD_LEN[i]);
      if (hit[i] && !found) begin
        found = 1'b1;
        code  = 4'(i);
      end
    end

    unique case (cur.phase)
      hrlp_pkg::PH_METHOD: begin
        if (byte_i == hrlp_pkg::CHAR_SP) begin
          if (found) begin
            nxt.mfound = code;
            nxt.phase  = hrlp_pkg::PH_URI;
          end else begin
            nxt.phase  = hrlp_pkg::PH_ERROR;
          end
        end else begin
          tag = hrlp_pkg::TAG_METHOD;
          if (cur.mlen < 4'(hrlp_pkg::METHOD_MAX)) begin
            for (int i = 0; i < hrlp_pkg::METHOD_CNT; i++) begin
              nxt.cand[i] = cur.cand[i] && (cur.mlen < hrlp_pkg::METHOD_LEN[i]) &&
                            (byte_i == hrlp_pkg::METHOD_TEXT[i][cur.mlen[2:0]]);
            end
            nxt.mlen = cur.mlen + 4'd1;
          end else begin
            // Longer than any method name: can never match.
            nxt.mlen = 4'd8;
            nxt.cand = '0;
          end
        end
      end
      hrlp_pkg::PH_URI: begin
        if (byte_i == hrlp_pkg::CHAR_SP) begin
          nxt.phase = hrlp_pkg::PH_SCAN;
        end else begin
          tag = hrlp_pkg::TAG_URI;
        end
      end
      hrlp_pkg::PH_SCAN: begin
        if (byte_i == hrlp_pkg::CHAR_LF) begin
          nxt.nl = 1'b1;
        end
        if (byte_i == hrlp_pkg::MARKER_TEXT[cur.mcnt]) begin
          cnt = cur.mcnt + 3'd1;
        end else begin
          cnt = (byte_i == hrlp_pkg::CHAR_H) ? 3'd1 : 3'd0;
        end
        if (cnt == 3'(hrlp_pkg::MARKER_LEN)) begin
          nxt.mcnt  = 3'd0;
          nxt.phase = hrlp_pkg::PH_VERSION;
        end else begin
          nxt.mcnt  = cnt;
        end
      end
      hrlp_pkg::PH_VERSION: begin
        if (!cur.nl && (byte_i == hrlp_pkg::CHAR_LF)) begin
          nxt.phase = hrlp_pkg::PH_TAIL;
        end else begin
          tag = hrlp_pkg::TAG_VERSION;
        end
      end
      hrlp_pkg::PH_TAIL, hrlp_pkg::PH_ERROR: begin
        nxt = cur;
      end
      default: begin
        nxt = cur;
      end
    endcase

    res_o.data  = byte_i;
    res_o.tag   = tag;
    res_o.done  = end_i;
    res_o.mcode = nxt.mfound;
    if (!end_i) begin
      res_o.status = hrlp_pkg::ST_PARSING;
    end else if ((nxt.phase == hrlp_pkg::PH_VERSION) || (nxt.phase == hrlp_pkg::PH_TAIL)) begin
      res_o.status = hrlp_pkg::ST_OK;
    end else begin
      res_o.status = hrlp_pkg::ST_ERROR;
    end

    st_o = end_i ? hrlp_pkg::PARSE_RESET : nxt;
  end

endmodule

// File: rtl/core/http_request_line_parser_core.sv
// ----------------------------------------------------------------------------
// HTTP request line parser core
// Tags each byte of a request message as method, URI, version or none and
// reports the request line status and method code on the last byte.
// ----------------------------------------------------------------------------
// Pipeline: an accepted word passes through the input register, then the result
//   register, and is offered on the result stream from there.
// Throughput: one word per cycle while the consumer keeps up; the only loop is
//   the parse context update, which is combinational.
// Reset: rst_ni clears both valid flags and returns the parse context to the
//   start of a message, asynchronously.
// ----------------------------------------------------------------------------
module http_request_line_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] msg_start
  input  logic        s_axis_tlast_i,   // msg_end
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] out_byte, [9:8] status,
                                        // [13:10] method_code, [15:14] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] field_tag
  output logic        m_axis_tlast_o    // done_res
);

  // Input register stage. The parse context is applied to the registered byte.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       in_end_q;

  // Result register stage.
  logic                 out_valid_q;
  hrlp_pkg::result_t    res_q;
  hrlp_pkg::result_t    res_d;

  // Parse context, updated whenever a word moves into the result register.
  hrlp_pkg::parse_state_t st_q;
  hrlp_pkg::parse_state_t st_d;

  logic advance;

  // The result register can take a new word when it is empty or being read.
  // The input register refills as soon as its word moves on, so both sides
  // run at one word per cycle while the consumer keeps up.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  hrlp_step u_step (
    .st_i    (st_q),
    .byte_i  (in_byte_q),
    .start_i (in_start_q),
    .end_i   (in_end_q),
    .st_o    (st_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= hrlp_pkg::PARSE_RESET;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset; they are qualified by the valid flags.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i;
      in_end_q   <= s_axis_tlast_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, res_q.mcode, res_q.status, res_q.data};
  assign m_axis_tuser_o  = res_q.tag;
  assign m_axis_tlast_o  = res_q.done;

endmodule

// File: rtl/core/hrlp_checker.sv
// ----------------------------------------------------------------------------
// HTTP request line parser checker
// Port-level properties of the parser core, attached by bind.
// ----------------------------------------------------------------------------
module hrlp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // A final status appears exactly on the last word of a message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tdata_o[9:8] != 2'd0)))
    else $error("status does not match last word");

  // Method codes stay in range and the padding bits stay clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[13:10] <= 4'd8) && (m_axis_tdata_o[15:14] == 2'd0))
    else $error("method code out of range or padding set");

  // While method bytes are still arriving no method has been accepted yet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == 2'd1) |-> (m_axis_tdata_o[13:10] == 4'd0))
    else $error("method code set inside the method field");

endmodule

bind http_request_line_parser_core hrlp_checker u_hrlp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
